>>> hdl/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg: shared types and constants of the quadratic probe hash table
// Sizes, field widths, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package qpht_pkg;

    // Table geometry. SLOTS must be a power of two: the probe index is the
    // low IDX_W bits of the key hash plus the probe offset, wrapping at SLOTS.
    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int VALUE_BITS = 32;

    // Port field widths.
    localparam int MODE_W    = 2;
    localparam int KEY_W     = 64;
    localparam int HASH_W    = 64;
    localparam int IN_VAL_W  = 32;
    localparam int STATUS_W  = 3;
    localparam int FOUND_W   = 32;
    localparam int OUT_CNT_W = 11;

    // Configuration registers.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 1'b1;
    localparam logic [CFG_W-1:0] LOAD_LIMIT_RST  = 7'd70;
    localparam logic [CFG_W-1:0] PROBE_LIMIT_RST = 7'd10;
    localparam int LOAD_SCALE = 100;
    localparam int LOAD_W     = CNT_W + 7;

    // Probe step counter, wide enough for the largest probe limit.
    localparam int J_W = CFG_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_REPLACED  = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_DELETED   = 3'd4,
        RES_FULL      = 3'd5,
        RES_CLEARED   = 3'd6
    } t_res;

    typedef enum logic [1:0] {
        SLOT_VACANT   = 2'd0,
        SLOT_OCCUPIED = 2'd1,
        SLOT_RELEASED = 2'd2
    } t_slot;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_PROBE,
        S_CLEAR,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic latch;     // capture the request
        logic start;     // load check, first probe issue
        logic probe;     // evaluate returned slot, issue next or finish
        logic sweep;     // write one slot vacant per cycle
        logic clr_fin;   // last sweep cycle of a clear request
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_clear;
        logic resolved;
        logic sweep_last;
    } t_dp_stat;

endpackage

>>> hdl/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl: request sequencer
// Walks each request through setup, probing or clearing, and result hand-off.
// ----------------------------------------------------------------------------
module qpht_ctrl
    import qpht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                if (i_stat.is_clear) n_state = S_CLEAR;
                else if (i_stat.resolved) n_state = S_DONE;
                else n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.resolved) n_state = S_DONE;
            end
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_START: begin
                o_cmd.start = 1'b1;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.clr_fin = i_stat.sweep_last;
            end
            S_DONE: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/qpht_dp.sv
// ----------------------------------------------------------------------------
// qpht_dp: table datapath
// Slot stores, probe address generation, slot evaluation, count and results.
// ----------------------------------------------------------------------------
module qpht_dp
    import qpht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [HASH_W-1:0]    i_key_hash,
    input  logic [IN_VAL_W-1:0]  i_value,
    output logic [STATUS_W-1:0]  o_status,
    output logic [FOUND_W-1:0]   o_found_value,
    output logic [OUT_CNT_W-1:0] o_entry_count
);

    // Configuration and control state.
    logic [CFG_W-1:0] r_load_limit;
    logic [CFG_W-1:0] r_probe_limit;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_sweep;

    // Request and probe state.
    t_mode                 r_mode;
    logic [KEY_W-1:0]      r_key;
    logic [IDX_W-1:0]      r_hash;
    logic [VALUE_BITS-1:0] r_value;
    logic [J_W-1:0]        r_j;
    logic [IDX_W-1:0]      r_ofs;
    logic [IDX_W-1:0]      r_addr;
    t_res                  r_res;
    logic [FOUND_W-1:0]    r_res_found;
    logic [STATUS_W-1:0]   r_status;
    logic [FOUND_W-1:0]    r_found;
    logic [OUT_CNT_W-1:0]  r_entry;

    // Memory ports.
    logic [IDX_W-1:0]      w_raddr;
    logic [IDX_W-1:0]      w_waddr;
    logic [KEY_W-1:0]      w_rd_key;
    logic [VALUE_BITS-1:0] w_rd_val;
    logic [1:0]            w_rd_st;
    logic                  w_we_key;
    logic                  w_we_val;
    logic                  w_we_st;
    logic [1:0]            w_st_wdata;

    // Decision logic.
    logic [LOAD_W-1:0] w_load_prod;
    logic [LOAD_W-1:0] w_load;
    logic              w_load_full;
    logic              w_exhausted;
    logic              w_key_eq;
    logic              w_resolved;
    t_res              w_res;
    logic [FOUND_W-1:0] w_found;
    logic              w_issue;
    logic              w_cnt_inc;
    logic              w_cnt_dec;

    assign w_load_prod = LOAD_W'(r_count) * LOAD_W'(LOAD_SCALE);
    assign w_load      = w_load_prod >> IDX_W;
    assign w_load_full = w_load >= LOAD_W'(r_load_limit);
    assign w_exhausted = (r_j + J_W'(1)) >= r_probe_limit;
    assign w_key_eq    = w_rd_key == r_key;
    assign w_raddr     = r_hash + r_ofs;
    assign w_waddr     = i_cmd.sweep ? r_sweep : r_addr;

    always_comb begin
        w_resolved = 1'b0;
        w_res      = RES_NOT_FOUND;
        w_found    = '0;
        w_issue    = 1'b0;
        w_we_key   = 1'b0;
        w_we_val   = 1'b0;
        w_we_st    = 1'b0;
        w_st_wdata = SLOT_VACANT;
        w_cnt_inc  = 1'b0;
        w_cnt_dec  = 1'b0;
        if (i_cmd.start) begin
            if (r_mode == MODE_CLEAR) begin
                w_resolved = 1'b0;
            end else if (r_mode == MODE_INSERT && w_load_full) begin
                w_resolved = 1'b1;
                w_res      = RES_FULL;
            end else if (r_probe_limit < CFG_W'(2)) begin
                w_resolved = 1'b1;
                w_res      = (r_mode == MODE_INSERT) ? RES_FULL : RES_NOT_FOUND;
            end else begin
                w_issue = 1'b1;
            end
        end else if (i_cmd.probe) begin
            if (r_mode == MODE_INSERT) begin
                if (w_rd_st != SLOT_OCCUPIED) begin
                    w_resolved = 1'b1;
                    w_res      = RES_INSERTED;
                    w_we_key   = 1'b1;
                    w_we_val   = 1'b1;
                    w_we_st    = 1'b1;
                    w_st_wdata = SLOT_OCCUPIED;
                    w_cnt_inc  = 1'b1;
                end else if (w_key_eq) begin
                    w_resolved = 1'b1;
                    w_res      = RES_REPLACED;
                    w_we_val   = 1'b1;
                end
            end else begin
                if (w_rd_st == SLOT_VACANT) begin
                    w_resolved = 1'b1;
                    w_res      = RES_NOT_FOUND;
                end else if (w_rd_st == SLOT_OCCUPIED && w_key_eq) begin
                    w_resolved = 1'b1;
                    if (r_mode == MODE_FIND) begin
                        w_res   = RES_FOUND;
                        w_found = FOUND_W'(w_rd_val);
                    end else begin
                        w_res      = RES_DELETED;
                        w_we_st    = 1'b1;
                        w_st_wdata = SLOT_RELEASED;
                        w_cnt_dec  = r_count != '0;
                    end
                end
            end
            // Nothing decided at this slot: give up or move on.
            if (!w_resolved) begin
                if (w_exhausted) begin
                    w_resolved = 1'b1;
                    w_res      = (r_mode == MODE_INSERT) ? RES_FULL : RES_NOT_FOUND;
                end else begin
                    w_issue = 1'b1;
                end
            end
        end
        if (i_cmd.sweep) begin
            w_we_st    = 1'b1;
            w_st_wdata = SLOT_VACANT;
        end
    end

    assign o_stat.is_clear   = r_mode == MODE_CLEAR;
    assign o_stat.resolved   = w_resolved;
    assign o_stat.sweep_last = r_sweep == IDX_W'(SLOTS - 1);

    qpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_key),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_key)
    );

    qpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_val),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_val)
    );

    qpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_st),
        .i_waddr (w_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_st)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit  <= LOAD_LIMIT_RST;
            r_probe_limit <= PROBE_LIMIT_RST;
            r_count       <= '0;
            r_sweep       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOAD_LIMIT:  r_load_limit  <= i_cfg_data;
                    CFG_PROBE_LIMIT: r_probe_limit <= i_cfg_data;
                    default: r_load_limit <= r_load_limit;
                endcase
            end
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + IDX_W'(1);
            end
            if (i_cmd.clr_fin) begin
                r_count <= '0;
            end else if (w_cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= t_mode'(i_mode);
            r_key   <= i_key;
            r_hash  <= i_key_hash[IDX_W-1:0];
            r_value <= VALUE_BITS'(i_value);
            r_j     <= '0;
            r_ofs   <= '0;
        end else if (w_issue) begin
            // Offset j + j*j advances by 2j + 2 from one probe to the next.
            r_addr <= w_raddr;
            r_ofs  <= r_ofs + IDX_W'({r_j, 1'b0} + (J_W + 1)'(2));
            r_j    <= r_j + J_W'(1);
        end
        if (i_cmd.clr_fin) begin
            r_res       <= RES_CLEARED;
            r_res_found <= '0;
        end else if (w_resolved) begin
            r_res       <= w_res;
            r_res_found <= w_found;
        end
        if (i_cmd.out_load) begin
            r_status <= r_res;
            r_found  <= r_res_found;
            r_entry  <= OUT_CNT_W'(r_count);
        end
    end

    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_count = r_entry;

endmodule

>>> hdl/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressing key/value table
// Insert, find, delete and clear over a quadratically probed slot table.
// ----------------------------------------------------------------------------
// Each request passes a setup step, one probed slot per cycle (0 to
//   probe_limit-1 slots) and a result step.
// A clear request sweeps the slot status store one slot a cycle.
// One request in flight: the next is taken the cycle after its result
//   is loaded. A result left waiting stalls the next load.
// Reset: synchronous, active low; a sweep over all SLOTS slots marks them vacant.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Request channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [HASH_W-1:0]    i_key_hash,
    input  logic [IN_VAL_W-1:0]  i_value,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [FOUND_W-1:0]   o_found_value,
    output logic [OUT_CNT_W-1:0] o_entry_count
);

    // The controller sequences every request; all data-dependent decisions
    // (slot state, key compare, load check, probe exhaustion) are made in the
    // datapath and reported back as a single "resolved" status.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    qpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the three slot stores (key, value, status), which
    // share one read address: the next probe slot is read while the current
    // one is evaluated, so the probe loop runs at one slot per cycle.
    qpht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_key_hash    (i_key_hash),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> hdl/qpht_chk.sv
// ----------------------------------------------------------------------------
// qpht_chk: port-level checker for the hash table
// Watches the top-level ports; attached by the bind at the end of this file.
// ----------------------------------------------------------------------------
module qpht_chk
    import qpht_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [MODE_W-1:0]    i_mode,
    input logic [KEY_W-1:0]     i_key,
    input logic [HASH_W-1:0]    i_key_hash,
    input logic [IN_VAL_W-1:0]  i_value,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [STATUS_W-1:0]  o_status,
    input logic [FOUND_W-1:0]   o_found_value,
    input logic [OUT_CNT_W-1:0] o_entry_count
);

    // A pending result is not withdrawn before its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped or changed while stalled");

    // Only one request is in flight: a transfer closes the request channel.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    // A clear leaves no entry behind.
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == RES_CLEARED |-> o_entry_count == '0)
        else $error("entry count not zero after clear");

    // Only a successful find carries a value.
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != RES_FOUND |-> o_found_value == '0)
        else $error("value returned on a result other than found");

    // The table never reports more entries than slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= OUT_CNT_W'(SLOTS))
        else $error("entry count beyond table size");

endmodule

bind quadratic_probe_hash_table qpht_chk u_qpht_chk (.*);
